[src/mslr_pkg.sv]
`timescale 1ns / 1ps

package mslr_pkg;

    localparam int COORD_W = 12;
    localparam int PIX_W   = COORD_W + 1;
    localparam int DEC_W   = COORD_W + 5;
    localparam int MAX_PIX = 4;
    localparam int IDX_W   = $clog2(MAX_PIX);
    localparam int CNT_W   = $clog2(MAX_PIX + 1);

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    typedef struct packed {
        logic               func;
        logic [COORD_W-1:0] x_begin;
        logic [COORD_W-1:0] y_begin;
        logic [COORD_W-1:0] x_finish;
        logic [COORD_W-1:0] y_finish;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
        logic             last;
        logic             bad_line;
    } out_item_t;

    // One accepted item's worth of pixels, as handed from front to back
    typedef struct packed {
        logic [CNT_W-1:0]              count;
        logic                          fin;
        logic                          bad;
        logic [MAX_PIX-1:0][PIX_W-1:0] xs;
        logic [MAX_PIX-1:0][PIX_W-1:0] ys;
    } job_t;

endpackage

[src/multi_step_line_rasterizer.sv]
`timescale 1ns / 1ps
// Path: a start or step beat is classified and queued at its accepting edge; its first
// pixel beat then passes from the queue into the output register that drives m_valid,
// when that register is empty or being drained.
// Throughput: one pixel beat per cycle while m_ready is high, set by the single-pixel
// output register; a step yields two to four pixels.
// Reset: aresetn synchronous active low; clears the line state, the queue and m_valid.
module multi_step_line_rasterizer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mslr_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mslr_pkg::out_item_t m_data
);

    logic           q_full, q_push, q_pop, q_valid;
    mslr_pkg::job_t wr_job, rd_job;

    mslr_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_job   (wr_job)
    );

    mslr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .wr_job   (wr_job),
        .full     (q_full),
        .pop      (q_pop),
        .rd_valid (q_valid),
        .rd_job   (rd_job)
    );

    mslr_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_job   (rd_job),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

[src/mslr_front.sv]
`timescale 1ns / 1ps

module mslr_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mslr_pkg::in_item_t s_data,
    input  logic              q_full,
    output logic              q_push,
    output mslr_pkg::job_t    q_job
);

    logic [mslr_pkg::PIX_W-1:0]          cur_x_reg, cur_x_next;
    logic [mslr_pkg::PIX_W-1:0]          cur_y_reg, cur_y_next;
    logic signed [mslr_pkg::DEC_W-1:0]   dec_reg, dec_next;
    logic signed [mslr_pkg::DEC_W-1:0]   mid_reg, mid_next;
    logic signed [mslr_pkg::DEC_W-1:0]   inc_a_reg, inc_a_next;
    logic signed [mslr_pkg::DEC_W-1:0]   inc_b_reg, inc_b_next;
    logic signed [mslr_pkg::DEC_W-1:0]   inc_c_reg, inc_c_next;
    logic                                steep_reg, steep_next;
    logic [mslr_pkg::COORD_W-1:0]        tgt_x_reg, tgt_x_next;
    logic [mslr_pkg::COORD_W-1:0]        tgt_y_reg, tgt_y_next;
    logic                                busy_reg, busy_next;

    logic                                accept;
    logic signed [mslr_pkg::COORD_W:0]   dx, dy;
    logic signed [mslr_pkg::DEC_W-1:0]   dx_d, dy_d, ib, cc;
    logic [2:0]                          ybits;
    logic [1:0]                          n_pix;
    logic [mslr_pkg::PIX_W-1:0]          ysum, new_x, new_y;
    logic [mslr_pkg::PIX_W:0]            x_plus1;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        dec_next   = dec_reg;
        mid_next   = mid_reg;
        inc_a_next = inc_a_reg;
        inc_b_next = inc_b_reg;
        inc_c_next = inc_c_reg;
        steep_next = steep_reg;
        tgt_x_next = tgt_x_reg;
        tgt_y_next = tgt_y_reg;
        busy_next  = busy_reg;
        q_push     = 1'b0;
        q_job      = '0;

        dx   = $signed({1'b0, s_data.x_finish}) - $signed({1'b0, s_data.x_begin});
        dy   = $signed({1'b0, s_data.y_finish}) - $signed({1'b0, s_data.y_begin});
        dx_d = mslr_pkg::DEC_W'(dx);
        dy_d = mslr_pkg::DEC_W'(dy);
        ib   = (dy_d <<< 2) - (dx_d <<< 1);
        cc   = (ib <= 0) ? (dy_d <<< 1) : ((dy_d - dx_d) <<< 1);

        // pixel pattern of one step: bit i set means y advances on pixel i
        ybits = 3'b000;
        n_pix = 2'd2;
        if (!steep_reg) begin
            if (dec_reg < 0) begin
                ybits = 3'b000;
            end else if (dec_reg >= mid_reg) begin
                ybits = 3'b001;
            end else begin
                ybits = 3'b010;
                n_pix = 2'd3;
            end
        end else begin
            if (dec_reg >= 0) begin
                ybits = 3'b011;
            end else if (dec_reg < mid_reg) begin
                ybits = 3'b010;
            end else begin
                ybits = 3'b101;
                n_pix = 2'd3;
            end
        end

        ysum = cur_y_reg;
        for (int i = 0; i < 3; i++) begin
            ysum = ysum + mslr_pkg::PIX_W'(ybits[i]);
            q_job.xs[i] = cur_x_reg + mslr_pkg::PIX_W'(i + 1);
            q_job.ys[i] = ysum;
        end
        new_x   = cur_x_reg + mslr_pkg::PIX_W'(n_pix);
        new_y   = ysum;
        x_plus1 = {1'b0, new_x} + 1'b1;

        if (accept && s_data.func == mslr_pkg::FUNC_START) begin
            q_push = 1'b1;
            q_job  = '0;
            if (dy < 0 || dy > dx) begin
                busy_next    = 1'b0;
                q_job.count  = mslr_pkg::CNT_W'(1);
                q_job.bad    = 1'b1;
            end else begin
                cur_x_next = mslr_pkg::PIX_W'(s_data.x_begin);
                cur_y_next = mslr_pkg::PIX_W'(s_data.y_begin);
                tgt_x_next = s_data.x_finish;
                tgt_y_next = s_data.y_finish;
                inc_b_next = ib;
                mid_next   = cc;
                inc_a_next = cc <<< 1;
                inc_c_next = ib + cc;
                steep_next = (ib > 0);
                dec_next   = (ib <= 0) ? ((cc <<< 1) - dx_d) : ((cc <<< 1) + dx_d);
                busy_next  = 1'b1;
                q_job.count = mslr_pkg::CNT_W'(1);
                q_job.xs[0] = mslr_pkg::PIX_W'(s_data.x_begin);
                q_job.ys[0] = mslr_pkg::PIX_W'(s_data.y_begin);
                // short line: the start alone reaches the end
                if ({2'b00, s_data.x_begin} + 1'b1 >= {2'b00, s_data.x_finish}) begin
                    busy_next = 1'b0;
                    q_job.fin = 1'b1;
                    if (s_data.x_begin < s_data.x_finish) begin
                        q_job.xs[1] = mslr_pkg::PIX_W'(s_data.x_finish);
                        q_job.ys[1] = mslr_pkg::PIX_W'(s_data.y_finish);
                        q_job.count = mslr_pkg::CNT_W'(2);
                    end
                end
            end
        end else if (accept && busy_reg) begin
            q_push      = 1'b1;
            q_job.count = mslr_pkg::CNT_W'(n_pix);
            cur_x_next  = new_x;
            cur_y_next  = new_y;
            unique case (ybits)
                3'b000:  dec_next = dec_reg + inc_a_reg;
                3'b011:  dec_next = dec_reg + inc_a_reg;
                3'b001:  dec_next = dec_reg + inc_b_reg;
                3'b010:  dec_next = (n_pix == 2'd3) ? dec_reg + inc_c_reg
                                                    : dec_reg + inc_b_reg;
                default: dec_next = dec_reg + inc_c_reg;
            endcase
            if (x_plus1 >= {2'b00, tgt_x_reg}) begin
                busy_next = 1'b0;
                q_job.fin = 1'b1;
                if (new_x < {1'b0, tgt_x_reg}) begin
                    q_job.xs[n_pix] = mslr_pkg::PIX_W'(tgt_x_reg);
                    q_job.ys[n_pix] = mslr_pkg::PIX_W'(tgt_y_reg);
                    q_job.count     = mslr_pkg::CNT_W'(n_pix) + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg <= '0;
            cur_y_reg <= '0;
            dec_reg   <= '0;
            mid_reg   <= '0;
            inc_a_reg <= '0;
            inc_b_reg <= '0;
            inc_c_reg <= '0;
            steep_reg <= 1'b0;
            tgt_x_reg <= '0;
            tgt_y_reg <= '0;
            busy_reg  <= 1'b0;
        end else begin
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            dec_reg   <= dec_next;
            mid_reg   <= mid_next;
            inc_a_reg <= inc_a_next;
            inc_b_reg <= inc_b_next;
            inc_c_reg <= inc_c_next;
            steep_reg <= steep_next;
            tgt_x_reg <= tgt_x_next;
            tgt_y_reg <= tgt_y_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

[src/mslr_queue.sv]
`timescale 1ns / 1ps

module mslr_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  mslr_pkg::job_t wr_job,
    output logic           full,
    input  logic           pop,
    output logic           rd_valid,
    output mslr_pkg::job_t rd_job
);

    mslr_pkg::job_t slot_mem [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           do_pop;

    assign full     = (cnt_reg == 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_job   = slot_mem[rd_ptr_reg];
    assign do_pop   = pop && rd_valid;

    always_comb begin
        wr_ptr_next = push   ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_mem[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

[src/mslr_back.sv]
`timescale 1ns / 1ps

module mslr_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  mslr_pkg::job_t     q_job,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output mslr_pkg::out_item_t m_data
);

    logic [mslr_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                       out_valid_reg, out_valid_next;
    mslr_pkg::out_item_t        out_data_reg, out_data_next;
    logic                       load, at_end;

    assign load   = q_valid && (!out_valid_reg || m_ready);
    assign at_end = ({1'b0, idx_reg} == q_job.count - 1'b1);
    assign q_pop  = load && at_end;

    always_comb begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (load) begin
            out_valid_next         = 1'b1;
            out_data_next.pixel_x  = q_job.xs[idx_reg];
            out_data_next.pixel_y  = q_job.ys[idx_reg];
            out_data_next.last     = q_job.fin && at_end;
            out_data_next.bad_line = q_job.bad;
            // advance through the job, back to the first pixel once it is spent
            idx_next = at_end ? '0 : idx_reg + 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

[src/mslr_checker.sv]
`timescale 1ns / 1ps

module mslr_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input mslr_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input mslr_pkg::out_item_t m_data
);

    // a stalled input beat holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input beat changed while stalled");

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // an error beat carries no coordinates and never ends a line
    a_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.bad_line |-> m_data.pixel_x == '0 && m_data.pixel_y == '0
                                       && !m_data.last)
        else $error("bad_line beat with pixel data");

    // reset empties the result side
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

endmodule

bind multi_step_line_rasterizer mslr_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 20;
    localparam int RANDOM_ITEMS = 385;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    mslr_pkg::in_item_t  s_data;
    logic                m_valid;
    logic                m_ready;
    mslr_pkg::out_item_t m_data;

    multi_step_line_rasterizer u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Shadow of the rasteriser's line state
    int                                 pen_x;
    int                                 pen_y;
    int                                 end_x;
    int                                 end_y;
    int                                 last_x;
    logic signed [mslr_pkg::DEC_W-1:0]  err_acc;
    logic signed [mslr_pkg::DEC_W-1:0]  err_mid;
    logic signed [mslr_pkg::DEC_W-1:0]  err_inc_a;
    logic signed [mslr_pkg::DEC_W-1:0]  err_inc_b;
    logic signed [mslr_pkg::DEC_W-1:0]  err_inc_c;
    bit                                 steep_line;
    bit                                 line_busy;

    mslr_pkg::out_item_t expected_pixels[$];
    int                  mismatches;
    int                  items_sent;
    int                  cycle_count;
    bit                  calm;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic mslr_pkg::in_item_t make_item(logic f, int xb, int yb, int xf, int yf);
        mslr_pkg::in_item_t it;
        it.func     = f;
        it.x_begin  = mslr_pkg::COORD_W'(xb);
        it.y_begin  = mslr_pkg::COORD_W'(yb);
        it.x_finish = mslr_pkg::COORD_W'(xf);
        it.y_finish = mslr_pkg::COORD_W'(yf);
        return it;
    endfunction

    // Step beats carry random endpoint fields, which the block ignores
    function automatic mslr_pkg::in_item_t make_step();
        return make_item(mslr_pkg::FUNC_STEP, $urandom_range(0, 4095),
                         $urandom_range(0, 4095), $urandom_range(0, 4095),
                         $urandom_range(0, 4095));
    endfunction

    task automatic push_pixel(input int x, input int y, input logic bad);
        mslr_pkg::out_item_t px;
        px.pixel_x  = mslr_pkg::PIX_W'(x);
        px.pixel_y  = mslr_pkg::PIX_W'(y);
        px.last     = 1'b0;
        px.bad_line = bad;
        expected_pixels.push_back(px);
    endtask

    task automatic advance(input int ddx, input int ddy);
        pen_x += ddx;
        pen_y += ddy;
        push_pixel(pen_x, pen_y, 1'b0);
    endtask

    // Close the line once the pen reaches the end: add the endpoint if short of it
    task automatic close_line();
        mslr_pkg::out_item_t px;
        if (pen_x >= last_x) begin
            if (pen_x < end_x)
                push_pixel(end_x, end_y, 1'b0);
            px = expected_pixels.pop_back();
            px.last = 1'b1;
            expected_pixels.push_back(px);
            line_busy = 1'b0;
        end
    endtask

    task automatic predict_pixels(input mslr_pkg::in_item_t it);
        int dx;
        int dy;
        int c;
        if (it.func == mslr_pkg::FUNC_START) begin
            dx = int'(it.x_finish) - int'(it.x_begin);
            dy = int'(it.y_finish) - int'(it.y_begin);
            if (dy < 0 || dy > dx) begin
                line_busy = 1'b0;
                push_pixel(0, 0, 1'b1);
                return;
            end
            pen_x  = int'(it.x_begin);
            pen_y  = int'(it.y_begin);
            end_x  = int'(it.x_finish);
            end_y  = int'(it.y_finish);
            last_x = end_x - 1;
            err_inc_b = mslr_pkg::DEC_W'(4 * dy - 2 * dx);
            if (err_inc_b <= 0) begin
                steep_line = 1'b0;
                c = 2 * dy;
                err_inc_a = mslr_pkg::DEC_W'(2 * c);
                err_acc = mslr_pkg::DEC_W'(2 * c - dx);
            end else begin
                steep_line = 1'b1;
                c = 2 * (dy - dx);
                err_inc_a = mslr_pkg::DEC_W'(2 * c);
                err_acc = mslr_pkg::DEC_W'(2 * c + dx);
            end
            err_mid   = mslr_pkg::DEC_W'(c);
            err_inc_c = err_inc_b + mslr_pkg::DEC_W'(c);
            line_busy = 1'b1;
            push_pixel(pen_x, pen_y, 1'b0);
            close_line();
            return;
        end
        if (!line_busy)
            return;
        if (!steep_line) begin
            if (err_acc < 0) begin
                advance(1, 0);
                advance(1, 0);
                err_acc += err_inc_a;
            end else if (err_acc >= err_mid) begin
                advance(1, 1);
                advance(1, 0);
                err_acc += err_inc_b;
            end else begin
                advance(1, 0);
                advance(1, 1);
                advance(1, 0);
                err_acc += err_inc_c;
            end
        end else begin
            if (err_acc >= 0) begin
                advance(1, 1);
                advance(1, 1);
                err_acc += err_inc_a;
            end else if (err_acc < err_mid) begin
                advance(1, 0);
                advance(1, 1);
                err_acc += err_inc_b;
            end else begin
                advance(1, 1);
                advance(1, 0);
                advance(1, 1);
                err_acc += err_inc_c;
            end
        end
        close_line();
    endtask

    // Hold valid and payload until the beat is taken, then predict its pixels
    task automatic send_item(input mslr_pkg::in_item_t it);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid = 1'b1;
        s_data  = it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_pixels(it);
        items_sent++;
    endtask

    task automatic draw_line(input int xb, input int yb, input int xf, input int yf,
                             input int max_steps);
        int n;
        n = 0;
        send_item(make_item(mslr_pkg::FUNC_START, xb, yb, xf, yf));
        while (line_busy && n < max_steps) begin
            send_item(make_step());
            n++;
        end
    endtask

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endtask

    always @(posedge aclk) begin
        mslr_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_pixels.size() == 0) begin
                note_mismatch($sformatf("unexpected pixel beat x=%0d y=%0d last=%0b bad=%0b",
                                        m_data.pixel_x, m_data.pixel_y, m_data.last,
                                        m_data.bad_line));
            end else begin
                want = expected_pixels.pop_front();
                if (m_data.pixel_x !== want.pixel_x || m_data.pixel_y !== want.pixel_y ||
                    m_data.last !== want.last || m_data.bad_line !== want.bad_line) begin
                    note_mismatch({
                        $sformatf("pixel mismatch: expected x=%0d y=%0d last=%0b bad=%0b, ",
                                  want.pixel_x, want.pixel_y, want.last, want.bad_line),
                        $sformatf("got x=%0d y=%0d last=%0b bad=%0b",
                                  m_data.pixel_x, m_data.pixel_y, m_data.last,
                                  m_data.bad_line)});
                end
            end
        end
    end

    // Result side back-pressure: bursts of ready, stalls mostly short
    initial begin
        int hold;
        hold = 0;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (calm) begin
                m_ready = 1'b1;
                hold = 0;
            end else if (hold > 0) begin
                hold--;
            end else begin
                m_ready = ($urandom_range(0, 3) != 0);
                hold = m_ready ? $urandom_range(0, 8) : pick_gap();
            end
        end
    end

    task automatic test_idle_step();
        send_item(make_step());
    endtask

    task automatic test_bad_octant();
        send_item(make_item(mslr_pkg::FUNC_START, 10, 20, 30, 5));
        send_item(make_item(mslr_pkg::FUNC_START, 0, 0, 5, 9));
        send_item(make_item(mslr_pkg::FUNC_START, 4095, 4095, 0, 0));
        send_item(make_item(mslr_pkg::FUNC_START, 0, 0, 0, 4095));
        send_item(make_step());
    endtask

    task automatic test_short_lines();
        draw_line(0, 0, 0, 0, 4);
        draw_line(4095, 4095, 4095, 4095, 4);
        draw_line(4094, 0, 4095, 0, 4);
        draw_line(4094, 4094, 4095, 4095, 4);
    endtask

    task automatic test_shallow_and_steep();
        draw_line(0, 0, 9, 3, 20);
        draw_line(100, 200, 108, 206, 20);
        draw_line(5, 5, 11, 11, 20);
    endtask

    task automatic test_restart();
        draw_line(0, 0, 4095, 4095, 2);
        draw_line(4088, 4090, 4095, 4095, 20);
        send_item(make_step());
    endtask

    task automatic test_random_lines();
        int stop_at;
        int r;
        int dx;
        int dy;
        int xb;
        int yb;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            // Every third stretch runs with no idling on either side
            calm = ((items_sent / 60) % 3 == 2);
            r = $urandom_range(0, 9);
            if (r < 7) begin
                r = $urandom_range(0, 9);
                if (r < 8)
                    dx = $urandom_range(0, 24);
                else if (r < 9)
                    dx = $urandom_range(25, 200);
                else
                    dx = $urandom_range(201, 4095);
                dy = $urandom_range(0, dx);
                xb = $urandom_range(0, 4095 - dx);
                yb = $urandom_range(0, 4095 - dy);
                if (dx > 200)
                    draw_line(xb, yb, xb + dx, yb + dy, $urandom_range(3, 30));
                else if ($urandom_range(0, 4) != 0)
                    draw_line(xb, yb, xb + dx, yb + dy, 4096);
                else
                    draw_line(xb, yb, xb + dx, yb + dy, $urandom_range(0, 3));
            end else if (r == 7) begin
                send_item(make_item(mslr_pkg::FUNC_START, $urandom_range(0, 4095),
                                    $urandom_range(0, 4095), $urandom_range(0, 4095),
                                    $urandom_range(0, 4095)));
            end else begin
                send_item(make_step());
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        mismatches  = 0;
        items_sent  = 0;
        cycle_count = 0;
        calm        = 1'b0;
        line_busy   = 1'b0;
        pen_x = 0;
        pen_y = 0;
        end_x = 0;
        end_y = 0;
        last_x = 0;
        err_acc = '0;
        err_mid = '0;
        err_inc_a = '0;
        err_inc_b = '0;
        err_inc_c = '0;
        steep_line = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_idle_step();
        test_bad_octant();
        test_short_lines();
        test_shallow_and_steep();
        test_restart();
        test_random_lines();

        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
